// File: sv/dwpi_pkg.sv
// ---------------------------------------------------------------------------
// dwpi_pkg: shared types, constants and functions
// Widths of the shared multiplier, feedforward tables and saturation helpers.
// ---------------------------------------------------------------------------
package dwpi_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // 24-bit integrator limits, held at 35 bits for the update sum
  localparam logic signed [34:0] INTEG_MAX = 35'sd8388607;
  localparam logic signed [34:0] INTEG_MIN = -35'sd8388608;

  localparam logic signed [34:0] SPEED_MAX = 35'sd32767;
  localparam logic signed [34:0] SPEED_MIN = -35'sd32768;

  // feedforward duty per band: below 50, 100, 200, 300, then 300 and up
  localparam logic [11:0] FF_L_POS [5] = '{12'd1000, 12'd700, 12'd500, 12'd300, 12'd0};
  localparam logic [11:0] FF_L_NEG [5] = '{12'd1000, 12'd1300, 12'd1500, 12'd1700, 12'd2000};
  localparam logic [11:0] FF_R_POS [5] = '{12'd1000, 12'd1300, 12'd1500, 12'd1700, 12'd2000};
  localparam logic [11:0] FF_R_NEG [5] = '{12'd1000, 12'd800, 12'd500, 12'd300, 12'd0};

  function automatic logic [11:0] ff_duty(input logic signed [12:0] target,
                                          input logic right);
    logic [13:0] mag;
    logic [2:0]  band;
    logic [11:0] val;
    mag = target[12] ? (14'd0 - {target[12], target}) : {1'b0, target};
    if (mag < 14'd50)       band = 3'd0;
    else if (mag < 14'd100) band = 3'd1;
    else if (mag < 14'd200) band = 3'd2;
    else if (mag < 14'd300) band = 3'd3;
    else                    band = 3'd4;
    case ({right, target[12]})
      2'b00:   val = FF_L_POS[band];
      2'b01:   val = FF_L_NEG[band];
      2'b10:   val = FF_R_POS[band];
      default: val = FF_R_NEG[band];
    endcase
    return val;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
    logic signed [15:0] res;
    if (v > SPEED_MAX)      res = 16'sh7FFF;
    else if (v < SPEED_MIN) res = 16'sh8000;
    else                    res = v[15:0];
    return res;
  endfunction

endpackage

// File: sv/dwpi_mul.sv
// ---------------------------------------------------------------------------
// dwpi_mul: shared signed multiplier
// One signed 33 x 17 product per cycle, registered at the output.
// ---------------------------------------------------------------------------
module dwpi_mul (
  input  logic                                  clk,
  input  logic signed [dwpi_pkg::MUL_A_W-1:0]   op_a,
  input  logic signed [dwpi_pkg::MUL_B_W-1:0]   op_b,
  output logic signed [dwpi_pkg::MUL_P_W-1:0]   prod
);

  logic signed [dwpi_pkg::MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

// File: sv/dual_wheel_pi_speed_control_core.sv
// ---------------------------------------------------------------------------
// dual_wheel_pi_speed_control_core: two-wheel PI speed loop with feedforward
// Per control tick: encoder deltas, speeds, PI with saturating integrators,
// staircase feedforward, duty clamp; all products on one shared multiplier.
// ---------------------------------------------------------------------------
// Sequence: the accept edge, then 7 steps per wheel and one output load step,
//   before out_tvalid rises.
// A new tick is taken only once the last one is loaded; the single shared
//   multiplier is the resource the product steps wait on.
// in_tready is low while a tick is in work; the output register frees the
//   input side once the result is loaded, even if out_tready is low.
// Reset (rst_n low, synchronous): configuration registers take their default values,
//   stored positions and integrators clear, no beat pending, in_tready low.
module dual_wheel_pi_speed_control_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // left_position[15:0], right_position[31:16],
                                  // left_target[44:32], right_target[57:45], zero pad
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // left_duty[11:0], right_duty[23:12],
                                  // left_speed[39:24], right_speed[55:40],
                                  // mean_speed[71:56]
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // register indexes
  localparam logic [2:0] REG_SPEED_SCALE = 3'd0;
  localparam logic [2:0] REG_PROP_GAIN   = 3'd1;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd2;
  localparam logic [2:0] REG_TICK_PERIOD = 3'd3;
  localparam logic [2:0] REG_DUTY_LIMIT  = 3'd4;

  // sequencer steps, run once per wheel (left first), then output load
  localparam logic [2:0] ST_SPD  = 3'd0; // issue delta * scale
  localparam logic [2:0] ST_ERR  = 3'd1; // speed and error from product
  localparam logic [2:0] ST_INC  = 3'd2; // issue error * period
  localparam logic [2:0] ST_INT  = 3'd3; // integrator update, issue error * kp
  localparam logic [2:0] ST_PRP  = 3'd4; // latch kp term, issue integ * ki
  localparam logic [2:0] ST_ACC  = 3'd5; // add ki term
  localparam logic [2:0] ST_DUTY = 3'd6; // round, feedforward, clamp
  localparam logic [2:0] ST_OUT  = 3'd7; // load output register

  // configuration registers
  logic [15:0] speed_scale_r, prop_gain_r, integ_gain_r, tick_period_r;
  logic [11:0] duty_limit_r;

  // control
  logic       busy_r;
  logic [2:0] step_r;
  logic       wheel_r;   // 0 = left, 1 = right
  logic       out_load;  // result moves into the output register

  // tick state
  logic [15:0]        last_lpos_r, last_rpos_r;
  logic signed [23:0] linteg_r, rinteg_r;

  // per-tick working registers
  logic signed [15:0] ldelta_r, rdelta_r;
  logic signed [12:0] ltarget_r, rtarget_r;
  logic signed [32:0] lsp_r, rsp_r;   // Q8 mm/s
  logic signed [32:0] err_r;          // Q8 error of the wheel in work
  logic signed [50:0] acc_r;          // PI sum before rounding
  logic [11:0]        lduty_r, rduty_r;

  // output register
  logic               out_valid_r;
  logic [11:0]        out_lduty_r, out_rduty_r;
  logic signed [15:0] out_lspd_r, out_rspd_r, out_mean_r;

  // input unpack
  logic [15:0]        in_lpos, in_rpos;
  logic signed [12:0] in_lt, in_rt;
  logic               in_beat;

  assign in_lpos = in_tdata[15:0];
  assign in_rpos = in_tdata[31:16];
  assign in_lt   = in_tdata[44:32];
  assign in_rt   = in_tdata[57:45];
  assign in_tready = rst_n && !busy_r;
  assign in_beat   = in_tvalid && in_tready;

  // output register is free or being emptied this cycle
  assign out_load = busy_r && (step_r == ST_OUT) && (!out_valid_r || out_tready);

  // shared multiplier
  logic signed [dwpi_pkg::MUL_A_W-1:0] mul_a;
  logic signed [dwpi_pkg::MUL_B_W-1:0] mul_b;
  logic signed [dwpi_pkg::MUL_P_W-1:0] prod;

  dwpi_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // wheel-selected operands
  logic signed [15:0] cur_delta;
  logic signed [12:0] cur_target;
  logic signed [23:0] cur_integ;

  assign cur_delta  = wheel_r ? rdelta_r  : ldelta_r;
  assign cur_target = wheel_r ? rtarget_r : ltarget_r;
  assign cur_integ  = wheel_r ? rinteg_r  : linteg_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      ST_SPD: begin
        mul_a = 33'(cur_delta);
        mul_b = $signed({1'b0, speed_scale_r});
      end
      ST_INC: begin
        mul_a = err_r;
        mul_b = $signed({1'b0, tick_period_r});
      end
      ST_INT: begin
        mul_a = err_r;
        mul_b = $signed({1'b0, prop_gain_r});
      end
      ST_PRP: begin
        mul_a = 33'(cur_integ);
        mul_b = $signed({1'b0, integ_gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // speed and error; the left wheel's count runs opposite, so its speed is negated
  logic signed [32:0] prod_sp;
  logic signed [32:0] tgt_q8;
  logic signed [32:0] err_nxt;
  logic signed [32:0] sp_nxt;

  assign prod_sp = prod[32:0];
  assign tgt_q8  = 33'(cur_target) <<< 8;
  assign sp_nxt  = wheel_r ? prod_sp : -prod_sp;
  assign err_nxt = wheel_r ? (tgt_q8 - prod_sp) : (tgt_q8 + prod_sp);

  // integrator increment, round half up, then saturate to 24 bits
  logic signed [49:0] inc_sum;
  logic signed [33:0] inc;
  logic signed [34:0] integ_sum;
  logic signed [23:0] integ_nxt;

  assign inc_sum   = prod + 50'sd32768;
  assign inc       = inc_sum[49:16];
  assign integ_sum = 35'(cur_integ) + 35'(inc);

  always_comb begin
    if (integ_sum > dwpi_pkg::INTEG_MAX)      integ_nxt = 24'sh7FFFFF;
    else if (integ_sum < dwpi_pkg::INTEG_MIN) integ_nxt = 24'sh800000;
    else                                      integ_nxt = integ_sum[23:0];
  end

  // PI rounding, feedforward and duty clamp
  logic signed [50:0] pi_sum;
  logic signed [34:0] pi_q0;
  logic signed [36:0] ff_ext;
  logic signed [36:0] duty_raw;
  logic [11:0]        duty_nxt;

  assign pi_sum   = acc_r + 51'sd32768;
  assign pi_q0    = pi_sum[50:16];
  assign ff_ext   = $signed({25'd0, dwpi_pkg::ff_duty(cur_target, wheel_r)});
  assign duty_raw = wheel_r ? (ff_ext + 37'(pi_q0)) : (ff_ext - 37'(pi_q0));

  always_comb begin
    if (duty_raw < 37'sd0)                                  duty_nxt = 12'd0;
    else if (duty_raw > $signed({25'd0, duty_limit_r}))     duty_nxt = duty_limit_r;
    else                                                    duty_nxt = duty_raw[11:0];
  end

  // reported speeds, round half up with 16-bit saturation
  logic signed [33:0] lspd_sum, rspd_sum;
  logic signed [34:0] mean_sum;
  logic signed [15:0] lspd, rspd, mean_spd;

  assign lspd_sum = 34'(lsp_r) + 34'sd128;
  assign rspd_sum = 34'(rsp_r) + 34'sd128;
  assign mean_sum = 35'(lsp_r) + 35'(rsp_r) + 35'sd256;
  assign lspd     = dwpi_pkg::sat16(35'($signed(lspd_sum[33:8])));
  assign rspd     = dwpi_pkg::sat16(35'($signed(rspd_sum[33:8])));
  assign mean_spd = dwpi_pkg::sat16(35'($signed(mean_sum[34:9])));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_scale_r <= 16'd6933;
      prop_gain_r   <= 16'd128;
      integ_gain_r  <= 16'd6144;
      tick_period_r <= 16'd655;
      duty_limit_r  <= 12'd2000;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SPEED_SCALE: speed_scale_r <= cfg_wdata;
        REG_PROP_GAIN:   prop_gain_r   <= cfg_wdata;
        REG_INTEG_GAIN:  integ_gain_r  <= cfg_wdata;
        REG_TICK_PERIOD: tick_period_r <= cfg_wdata;
        REG_DUTY_LIMIT:  duty_limit_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= ST_SPD;
      wheel_r     <= 1'b0;
      out_valid_r <= 1'b0;
      last_lpos_r <= '0;
      last_rpos_r <= '0;
      linteg_r    <= '0;
      rinteg_r    <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (in_beat) begin
        busy_r      <= 1'b1;
        step_r      <= ST_SPD;
        wheel_r     <= 1'b0;
        last_lpos_r <= in_lpos;
        last_rpos_r <= in_rpos;
      end else if (busy_r) begin
        case (step_r)
          ST_SPD:  step_r <= ST_ERR;
          ST_ERR:  step_r <= ST_INC;
          ST_INC:  step_r <= ST_INT;
          ST_INT: begin
            step_r <= ST_PRP;
            if (wheel_r) rinteg_r <= integ_nxt;
            else         linteg_r <= integ_nxt;
          end
          ST_PRP:  step_r <= ST_ACC;
          ST_ACC:  step_r <= ST_DUTY;
          ST_DUTY: begin
            if (wheel_r) begin
              step_r <= ST_OUT;
            end else begin
              wheel_r <= 1'b1;
              step_r  <= ST_SPD;
            end
          end
          ST_OUT: begin
            // wait here until the output register is free
            if (out_load) begin
              busy_r  <= 1'b0;
              wheel_r <= 1'b0;
              step_r  <= ST_SPD;
            end
          end
          default: step_r <= ST_SPD;
        endcase
      end
    end
  end

  // working datapath registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      ldelta_r  <= $signed(in_lpos - last_lpos_r);
      rdelta_r  <= $signed(in_rpos - last_rpos_r);
      ltarget_r <= in_lt;
      rtarget_r <= in_rt;
    end else if (busy_r) begin
      case (step_r)
        ST_ERR: begin
          err_r <= err_nxt;
          if (wheel_r) rsp_r <= sp_nxt;
          else         lsp_r <= sp_nxt;
        end
        ST_PRP:  acc_r <= 51'(prod);
        ST_ACC:  acc_r <= acc_r + 51'(prod);
        ST_DUTY: begin
          if (wheel_r) rduty_r <= duty_nxt;
          else         lduty_r <= duty_nxt;
        end
        ST_OUT: begin
          if (out_load) begin
            out_lduty_r <= lduty_r;
            out_rduty_r <= rduty_r;
            out_lspd_r  <= lspd;
            out_rspd_r  <= rspd;
            out_mean_r  <= mean_spd;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_mean_r, out_rspd_r, out_lspd_r, out_rduty_r, out_lduty_r};

  // checks
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a tick was in work");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r && step_r == ST_OUT))
    else $error("result shown without the output load step");

  a_duty_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_lduty_r <= duty_limit_r) && (out_rduty_r <= duty_limit_r))
    else $error("duty above the limit");

  a_idle_left_wheel: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !wheel_r && step_r == ST_SPD)
    else $error("sequencer not parked while idle");

endmodule
